[rtl/piq_pkg.sv]
// ----------------------------------------------------------------------------
// piq_pkg: shared types and constants for the positional insert queue
// Holds the command codes, the per-cell control request and the result
// payload that travels down the output pipeline.
// ----------------------------------------------------------------------------
package piq_pkg;

  // Command codes as they arrive on the cmd port.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SERVE  = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_FIND
  } cell_op_t;

  // Control broadcast to the cells in the cycle a request is accepted.
  typedef struct packed {
    cell_op_t    op;
    logic [3:0]  pos;
    logic [7:0]  symbol;
  } cell_ctrl_t;

  // Result fields other than the found position.
  typedef struct packed {
    logic [7:0]  removed;
    logic [4:0]  total;
    logic        error;
  } res_t;

  // Found position reported when no slot matches (-1 in five bits).
  localparam logic [4:0] FOUND_NONE = 5'h1F;

  // Width of the position field.
  localparam int POS_W = 4;

  // Number of slots the position field can address.
  localparam int POS_SLOTS = 16;

  // Cells per group in the match search.
  localparam int GRP_SIZE = 8;

endpackage

[rtl/piq_cell.sv]
// ----------------------------------------------------------------------------
// piq_cell: one slot of the insertion queue
// Holds one byte. On insert it takes its left neighbor or the new symbol,
// on remove it takes its right neighbor, and on find it compares its byte.
// ----------------------------------------------------------------------------
module piq_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  piq_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       count,
  input  logic [7:0]          left_data,
  input  logic [7:0]          right_data,
  output logic [7:0]          data,
  output logic                match
);
  import piq_pkg::*;

  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  logic [CMP_W-1:0] idx_c;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] count_c;
  logic [7:0]       data_next;

  assign idx_c   = CMP_W'(INDEX);
  assign pos_c   = CMP_W'(ctrl.pos);
  assign count_c = CMP_W'(count);

  // Pick the next byte from the broadcast operation and this slot's place.
  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (idx_c > pos_c) begin
          data_next = left_data;
        end else if (idx_c == pos_c) begin
          data_next = ctrl.symbol;
        end
      end
      OP_REMOVE: begin
        if (idx_c >= pos_c) begin
          data_next = right_data;
        end
      end
      OP_HOLD, OP_FIND: begin
        data_next = data;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= 8'd0;
    end else begin
      data <= data_next;
    end
  end

  // A slot matches only while it holds a live entry.
  assign match = (ctrl.op == OP_FIND) && (idx_c < count_c) && (data == ctrl.symbol);

endmodule

[rtl/piq_search.sv]
// ----------------------------------------------------------------------------
// piq_search: last-match search over the registered match vector
// Registers a hit flag and the last hit inside each group of eight cells,
// then picks the last group with a hit and forms the five-bit position.
// ----------------------------------------------------------------------------
module piq_search #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic [DEPTH-1:0] match,
  output logic [4:0]       found
);
  import piq_pkg::*;

  localparam int NG    = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_W = NG * GRP_SIZE;

  logic [PAD_W-1:0] padded;
  logic [NG-1:0]    grp_any;
  logic [2:0]       grp_idx [NG];
  logic             hit;
  logic [8:0]       sel_full;

  // Last set bit of an eight-bit group.
  function automatic logic [2:0] last_set(input logic [GRP_SIZE-1:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < GRP_SIZE; i++) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  assign padded = PAD_W'(match);

  // Group stage: one hit flag and one local index per group.
  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_any[g] <= |padded[g*GRP_SIZE +: GRP_SIZE];
      grp_idx[g] <= last_set(padded[g*GRP_SIZE +: GRP_SIZE]);
    end
  end

  // The last group with a hit gives the upper bits of the position.
  always_comb begin
    hit      = 1'b0;
    sel_full = 9'd0;
    for (int g = 0; g < NG; g++) begin
      if (grp_any[g]) begin
        hit      = 1'b1;
        sel_full = {6'(g), grp_idx[g]};
      end
    end
    found = hit ? sel_full[4:0] : FOUND_NONE;
  end

endmodule

[rtl/positional_insert_queue.sv]
// ----------------------------------------------------------------------------
// positional_insert_queue: ordered byte line with positional insert/remove
// A row of DEPTH cells holds the entries in order; every command shifts or
// compares in all cells at once, followed by a short result pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   A request (cmd, position, symbol) is taken at a rising edge where start
//   is high and busy is low. busy stays low: the cell row updates in the
//   cycle a request is taken, so a new request may follow every cycle.
//   Commands: insert at position, remove at position, serve the front entry,
//   find the last slot holding symbol.
//   Each request gives exactly one result: found_position, removed_symbol,
//   entry_total and error, shown for one cycle with done high.
//   done and the result come from the output register. The accepting edge
//   updates the cells and captures the match vector in the first result
//   stage; the group stage of the match search registers after it, and
//   the output register then loads the combinational final position select.
//   Throughput is one request per cycle.
//   The receiver cannot stall; results leave in request order.
//   Reset clears every cell to zero, empties the line and drops any
//   results still in the pipeline.
// ----------------------------------------------------------------------------
module positional_insert_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd,
  input  logic [3:0]        position,
  input  logic [7:0]        symbol,
  output logic              done,
  output logic signed [4:0] found_position,
  output logic [7:0]        removed_symbol,
  output logic [4:0]        entry_total,
  output logic              error
);
  import piq_pkg::*;

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CMP_W-1:0] count_c;
  logic [CMP_W-1:0] pos_c;
  logic             accept;
  cell_ctrl_t       ctrl;
  logic             err_now;
  logic [7:0]       removed_now;
  logic [CW+4:0]    total_wide;

  logic [7:0]       cell_data [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [7:0]       low_bytes [POS_SLOTS];

  logic             s1_valid;
  logic [DEPTH-1:0] s1_match;
  res_t             s1_res;
  logic             s2_valid;
  res_t             s2_res;
  logic [4:0]       found_sel;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign count_c = CMP_W'(count);
  assign pos_c   = CMP_W'(position);

  // Decode the request into a cell operation, error flag and new count.
  always_comb begin
    ctrl.op     = OP_HOLD;
    ctrl.pos    = position;
    ctrl.symbol = symbol;
    err_now     = 1'b0;
    count_next  = count;
    removed_now = 8'd0;
    unique case (cmd_t'(cmd))
      CMD_INSERT: begin
        if ((count == CW'(DEPTH)) || (pos_c > count_c)) begin
          err_now = 1'b1;
        end else begin
          ctrl.op    = OP_INSERT;
          count_next = count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if ((count == '0) || (pos_c >= count_c)) begin
          err_now = 1'b1;
        end else begin
          ctrl.op     = OP_REMOVE;
          count_next  = count - 1'b1;
          removed_now = low_bytes[position];
        end
      end
      CMD_SERVE: begin
        if (count == '0) begin
          err_now = 1'b1;
        end else begin
          ctrl.op     = OP_REMOVE;
          ctrl.pos    = '0;
          count_next  = count - 1'b1;
          removed_now = cell_data[0];
        end
      end
      CMD_FIND: begin
        ctrl.op = OP_FIND;
      end
      default: begin
        ctrl.op = OP_HOLD;
      end
    endcase
    if (!accept) begin
      ctrl.op    = OP_HOLD;
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The row of cells; the ends see zero from outside.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] left_in;
    logic [7:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = 8'd0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = 8'd0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    piq_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .count      (count),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  // Slots the position field can name, for reading the removed byte.
  for (genvar k = 0; k < POS_SLOTS; k++) begin : g_low
    if (k < DEPTH) begin : g_have
      assign low_bytes[k] = cell_data[k];
    end else begin : g_none
      assign low_bytes[k] = 8'd0;
    end
  end

  assign total_wide = {5'd0, count_next};

  // First result stage: match vector and payload of the accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_match       <= accept ? cell_match : '0;
    s1_res.removed <= removed_now;
    s1_res.total   <= total_wide[4:0];
    s1_res.error   <= err_now;
  end

  piq_search #(
    .DEPTH (DEPTH)
  ) u_search (
    .clk   (clk),
    .match (s1_match),
    .found (found_sel)
  );

  // Second stage keeps the payload in step with the group search.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_res <= s1_res;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    found_position <= found_sel;
    removed_symbol <= s2_res.removed;
    entry_total    <= s2_res.total;
    error          <= s2_res.error;
  end

endmodule
